FILE: rtl/kwsc_pkg.sv
`default_nettype none

package kwsc_pkg;

  localparam int unsigned NUM_LETTERS = 26;

  localparam logic [4:0] LAST_LETTER = 5'd25;
  localparam logic [7:0] LETTER_A    = 8'h61;
  localparam logic [7:0] LETTER_Z    = 8'h7A;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_KEY    = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_TEXT   = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_FILL
  } kwsc_state_t;

  typedef struct packed {
    logic       clr;
    logic       place;
    logic [4:0] idx;
  } tbl_cmd_t;

  function automatic logic is_lower(input logic [7:0] b);
    return (b >= LETTER_A) && (b <= LETTER_Z);
  endfunction

  function automatic logic [4:0] letter_idx(input logic [7:0] b);
    logic [7:0] diff;
    diff = b - LETTER_A;
    return diff[4:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/kwsc_table.sv
`default_nettype none

module kwsc_table (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kwsc_pkg::tbl_cmd_t cmd,
  input  wire logic              lk_en,
  input  wire logic [4:0]        lk_idx,
  output logic [4:0]             lk_data
);
  import kwsc_pkg::*;

  logic [4:0]             table_r [NUM_LETTERS];
  logic [NUM_LETTERS-1:0] seen_r;
  logic [NUM_LETTERS-1:0] seen_nxt;
  logic [4:0]             fill_r;
  logic [4:0]             fill_nxt;
  logic [4:0]             lk_data_r;
  logic                   do_place;
  logic                   do_write;

  assign do_place = cmd.place && (cmd.idx <= LAST_LETTER) && !seen_r[cmd.idx];
  assign do_write = do_place && (fill_r < 5'(NUM_LETTERS));

  always_comb begin
    seen_nxt = seen_r;
    fill_nxt = fill_r;
    if (cmd.clr) begin
      seen_nxt = '0;
      fill_nxt = '0;
    end else if (do_place) begin
      seen_nxt[cmd.idx] = 1'b1;
      if (do_write) begin
        fill_nxt = fill_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      fill_r <= '0;
    end else begin
      seen_r <= seen_nxt;
      fill_r <= fill_nxt;
    end
  end

  // entries at or beyond the fill point read as letter a
  always_ff @(posedge clk) begin
    if (!cmd.clr && do_write) begin
      table_r[fill_r] <= cmd.idx;
    end
    if (lk_en) begin
      lk_data_r <= (lk_idx < fill_r) ? table_r[lk_idx] : 5'd0;
    end
  end

  assign lk_data = lk_data_r;

endmodule

`default_nettype wire

FILE: rtl/kwsc_seq.sv
`default_nettype none

module kwsc_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_func,
  input  wire logic [7:0]         in_byte,
  input  wire logic               out_free,
  output logic                    in_ready,
  output logic                    text_fire,
  output kwsc_pkg::tbl_cmd_t      cmd
);
  import kwsc_pkg::*;

  kwsc_state_t state_r;
  kwsc_state_t state_nxt;
  logic [4:0]  cnt_r;
  logic [4:0]  cnt_nxt;
  logic        accept;

  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_func == FUNC_FINISH)) begin
          state_nxt = ST_FILL;
          cnt_nxt   = LAST_LETTER;
        end
      end
      ST_FILL: begin
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    text_fire = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_START: cmd.clr = 1'b1;
            FUNC_KEY: begin
              cmd.place = is_lower(in_byte);
              cmd.idx   = letter_idx(in_byte);
            end
            FUNC_TEXT: text_fire = 1'b1;
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        // walk z down to a; the table drops letters already seen
        cmd.place = 1'b1;
        cmd.idx   = cnt_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/keyword_substitution_cipher.sv
// Keyword substitution cipher.
// Input channel (in_valid/in_ready, in_func, in_byte) takes one beat per item:
//   start clears the key, key adds a keyword letter, finish completes the
//   alphabet, text encrypts one byte. Only text beats produce a result.
// Result channel (out_valid/out_ready, out_byte) carries one ciphertext byte
//   per text beat, in order, from an output register.
// A text result is valid the cycle after its beat is accepted. Back-to-back start,
//   key and text items run at one per cycle while out_ready holds high.
// After a finish beat the placement unit visits z down to a, one letter per cycle,
//   and in_ready stays low meanwhile.
// While out_valid is high and out_ready is low, in_ready drops until the
//   pending result is taken; no result is lost or repeated.
// Reset (rst_n low, synchronous) empties the key and the output register.
// Text sent before the first finish maps unplaced letters to 'a'.
`default_nettype none

module keyword_substitution_cipher (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte
);
  import kwsc_pkg::*;

  tbl_cmd_t   cmd;
  logic       text_fire;
  logic       out_free;
  logic [4:0] lk_data;
  logic       out_valid_r;
  logic       lower_r;
  logic [7:0] text_r;

  assign out_free = !out_valid_r || out_ready;

  kwsc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_byte   (in_byte),
    .out_free  (out_free),
    .in_ready  (in_ready),
    .text_fire (text_fire),
    .cmd       (cmd)
  );

  kwsc_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .lk_en   (text_fire),
    .lk_idx  (letter_idx(in_byte)),
    .lk_data (lk_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (text_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_fire) begin
      lower_r <= is_lower(in_byte);
      text_r  <= in_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = lower_r ? (LETTER_A + {3'b000, lk_data}) : text_r;

endmodule

`default_nettype wire
